// File: src/counter_hash_uniform_init_defines.svh
// Assertion macros shared by the weight init generator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef COUNTER_HASH_UNIFORM_INIT_DEFINES_SVH
`define COUNTER_HASH_UNIFORM_INIT_DEFINES_SVH

// Same-cycle implication, checks suspended while reset is high.
`define CHUI_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checks suspended while reset is high.
`define CHUI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/chui_pkg.sv
// Shared types and constants for the counter-hash weight init generator.
// No dependencies; imported by chui_ctrl, chui_mix and the top level.
`default_nettype none

package chui_pkg;

  // SplitMix64 constants
  localparam logic [63:0] GOLDEN_INC = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94D0_49BB_1331_11EB;

  // Field widths
  localparam int IDX_FIELD_W = 32;
  localparam int VALUE_W     = 32;
  localparam int BOUND_W     = 24;

  // Pipeline depth: two mixers of five stages, product stage, output stage
  localparam int MIX_STAGES = 5;
  localparam int STAGES     = 2 * MIX_STAGES + 2;

  // Register map, index = paddr[5:3]
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_SEED        = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STREAM_KEY  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_USE_UNIFORM = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOUND_Q22   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FILL_VALUE  = 3'd4;

  // Per-stage pipeline control
  typedef struct packed {
    logic [STAGES-1:0] en;     // stage register loads this cycle
    logic [STAGES-1:0] valid;  // stage register holds a word
  } pipe_ctrl_t;

endpackage

`default_nettype wire

// File: src/chui_ctrl.sv
// Valid/stall control for the generator pipeline, plus the last-flag lane.
// Depends on chui_pkg (STAGES, pipe_ctrl_t).
`default_nettype none

module chui_ctrl import chui_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tlast,
  input  logic       m_tready,
  output pipe_ctrl_t ctrl,
  output logic       last_out
);

  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] last;
  logic [STAGES-1:0] en;

  // A stage loads when it is empty or its word moves on; bubbles collapse
  always_comb begin
    en[STAGES-1] = !valid[STAGES-1] || m_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  // Last flag travels beside the data
  always_ff @(posedge clk) begin
    if (en[0]) begin
      last[0] <= s_tlast;
    end
    for (int i = 1; i < STAGES; i++) begin
      if (en[i]) begin
        last[i] <= last[i-1];
      end
    end
  end

  assign ctrl.en    = en;
  assign ctrl.valid = valid;
  assign last_out   = last[STAGES-1];

endmodule

`default_nettype wire

// File: src/chui_mix.sv
// SplitMix64 finalizer as a five-stage datapath; 64-bit products are split
// into 32x32 partial products. Depends on chui_pkg (constants, MIX_STAGES).
`default_nettype none

module chui_mix import chui_pkg::*; (
  input  logic                  clk,
  input  logic [MIX_STAGES-1:0] en,
  input  logic [63:0]           din,
  output logic [63:0]           dout
);

  logic [63:0] v0;
  logic [63:0] x1;
  logic [63:0] a_ll;
  logic [31:0] a_lh;
  logic [31:0] a_hl;
  logic [31:0] a_cross;
  logic [63:0] pa;
  logic [63:0] x3;
  logic [63:0] b_ll;
  logic [31:0] b_lh;
  logic [31:0] b_hl;
  logic [31:0] b_cross;
  logic [63:0] pb;
  logic [63:0] x5;

  // Stage 0: add golden increment, xorshift 30
  assign v0 = din + GOLDEN_INC;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1 <= v0 ^ (v0 >> 30);
    end
  end

  // Stage 1: partial products of x1 * MIX_MUL_A, low 64 bits only
  always_ff @(posedge clk) begin
    if (en[1]) begin
      a_ll <= {32'd0, x1[31:0]} * {32'd0, MIX_MUL_A[31:0]};
      a_lh <= x1[31:0] * MIX_MUL_A[63:32];
      a_hl <= x1[63:32] * MIX_MUL_A[31:0];
    end
  end

  // Stage 2: combine, xorshift 27
  assign a_cross = a_lh + a_hl;
  assign pa      = a_ll + {a_cross, 32'd0};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      x3 <= pa ^ (pa >> 27);
    end
  end

  // Stage 3: partial products of x3 * MIX_MUL_B
  always_ff @(posedge clk) begin
    if (en[3]) begin
      b_ll <= {32'd0, x3[31:0]} * {32'd0, MIX_MUL_B[31:0]};
      b_lh <= x3[31:0] * MIX_MUL_B[63:32];
      b_hl <= x3[63:32] * MIX_MUL_B[31:0];
    end
  end

  // Stage 4: combine, xorshift 31
  assign b_cross = b_lh + b_hl;
  assign pb      = b_ll + {b_cross, 32'd0};

  always_ff @(posedge clk) begin
    if (en[4]) begin
      x5 <= pb ^ (pb >> 31);
    end
  end

  assign dout = x5;

endmodule

`default_nettype wire

// File: src/counter_hash_uniform_init.sv
// Counter-hash weight init generator: one weight word per element index.
//
// Input stream (s_*): one word per element, s_tdata = element_index, s_tlast
// marks the last element of a tensor. Output stream (m_*): one word per input,
// in order, m_tdata = signed Q9.22 weight, m_tlast = copied last mark.
// Uniform mode: value = ((2m - 2^24) * bound_q22) >> 24 with m the top 24 bits
// of mix(seed ^ mix(stream_key) ^ mix(index)); fill mode returns fill_value.
// Configuration through the APB port, 64-bit registers at byte address 8*i:
// seed, stream_key, use_uniform, bound_q22, fill_value. Write only while the
// pipeline is empty.
// Throughput: one word per cycle while m_tready is high. Datapath: two
// rounds of five-stage SplitMix64 units (two side by side, then one), each
// with two split 64-bit multiplies, then a 25x25 scale multiply stage and
// the output register. Stall: a stage holds its word while the next is full
// and held, so bubbles close up; s_tready drops only with all 12 stages full.
// Reset (rst, synchronous): pipeline emptied, registers return to seed 0,
// stream_key 0, use_uniform 1, bound_q22 0, fill_value 0.
// Depends on chui_pkg, chui_ctrl, chui_mix and the assertion macro header.
`default_nettype none

`include "counter_hash_uniform_init_defines.svh"

module counter_hash_uniform_init import chui_pkg::*; #(
  parameter int INDEX_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] element_index
  input  logic        s_tlast,   // final_in
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] weight_value
  output logic        m_tlast    // final_out
);

  localparam int IDX_W = (INDEX_BITS < IDX_FIELD_W) ? INDEX_BITS : IDX_FIELD_W;
  localparam int PROD_W = 2 * (BOUND_W + 1);

  logic [63:0]          seed;
  logic [63:0]          stream_key;
  logic                 use_uniform;
  logic [BOUND_W-1:0]   bound_q22;
  logic [VALUE_W-1:0]   fill_value;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  pipe_ctrl_t           ctrl;
  logic                 last_out;

  logic [63:0]          idx_word;
  logic [63:0]          idx_hash;
  logic [63:0]          key_hash;
  logic [63:0]          mixed_in;
  logic [63:0]          final_hash;
  logic [BOUND_W:0]     centered;
  logic [PROD_W-1:0]    prod;
  logic [VALUE_W-1:0]   shifted;
  logic [VALUE_W-1:0]   out_data;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      seed        <= '0;
      stream_key  <= '0;
      use_uniform <= 1'b1;
      bound_q22   <= '0;
      fill_value  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SEED:        seed        <= pwdata;
        REG_STREAM_KEY:  stream_key  <= pwdata;
        REG_USE_UNIFORM: use_uniform <= pwdata[0];
        REG_BOUND_Q22:   bound_q22   <= pwdata[BOUND_W-1:0];
        REG_FILL_VALUE:  fill_value  <= pwdata[VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      REG_SEED:        prdata = seed;
      REG_STREAM_KEY:  prdata = stream_key;
      REG_USE_UNIFORM: prdata = {63'd0, use_uniform};
      REG_BOUND_Q22:   prdata = {{(64-BOUND_W){1'b0}}, bound_q22};
      REG_FILL_VALUE:  prdata = {{(64-VALUE_W){1'b0}}, fill_value};
      default:         prdata = '0;
    endcase
  end

  // Stall control and last-flag lane
  chui_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .m_tready (m_tready),
    .ctrl     (ctrl),
    .last_out (last_out)
  );

  assign s_tready = ctrl.en[0];

  // First hash round: index and stream key side by side
  assign idx_word = 64'(s_tdata[IDX_W-1:0]);

  chui_mix u_mix_idx (
    .clk  (clk),
    .en   (ctrl.en[MIX_STAGES-1:0]),
    .din  (idx_word),
    .dout (idx_hash)
  );

  chui_mix u_mix_key (
    .clk  (clk),
    .en   (ctrl.en[MIX_STAGES-1:0]),
    .din  (stream_key),
    .dout (key_hash)
  );

  // Second hash round on the combined word
  assign mixed_in = seed ^ key_hash ^ idx_hash;

  chui_mix u_mix_out (
    .clk  (clk),
    .en   (ctrl.en[2*MIX_STAGES-1:MIX_STAGES]),
    .din  (mixed_in),
    .dout (final_hash)
  );

  // Scale stage: 2m - 2^24 is m*2 with its top bit flipped
  assign centered = {~final_hash[63], final_hash[62:40], 1'b0};

  always_ff @(posedge clk) begin
    if (ctrl.en[2*MIX_STAGES]) begin
      prod <= PROD_W'($signed(centered) * $signed({1'b0, bound_q22}));
    end
  end

  // Output stage: floor shift by 24, sign extend, or fill constant
  assign shifted = VALUE_W'($signed(prod[PROD_W-1:BOUND_W]));

  always_ff @(posedge clk) begin
    if (ctrl.en[STAGES-1]) begin
      out_data <= use_uniform ? shifted : fill_value;
    end
  end

  assign m_tvalid = ctrl.valid[STAGES-1];
  assign m_tdata  = out_data;
  assign m_tlast  = last_out;

  // Checks
  `CHUI_ASSERT_NEXT(a_accept_fills_stage0, clk, rst, s_tvalid && s_tready, ctrl.valid[0], "accepted word did not enter stage 0")
  `CHUI_ASSERT_IMPLY(a_empty_stage0_ready, clk, rst, !ctrl.valid[0], s_tready, "input stalled with stage 0 empty")
  `CHUI_ASSERT_IMPLY(a_sink_ready_no_stall, clk, rst, m_tready, s_tready, "input stalled while output drains")
  `CHUI_ASSERT_IMPLY(a_reset_empties, clk, rst, $past(rst), !m_tvalid, "output valid right after reset")

endmodule

`default_nettype wire
